FILE: hdl/m4vt_pkg.sv
// ----------------------------------------------------------------------------
// m4vt_pkg
// Shared types and constants of the 4x4 matrix times vector core.
// ----------------------------------------------------------------------------
`default_nettype none

package m4vt_pkg;

    // matrix size and data widths
    localparam int NUM_CELLS = 4;
    localparam int IDX_BITS  = 2;
    localparam int COEF_BITS = 32;
    localparam int PROD_BITS = 2 * COEF_BITS;
    localparam int ACC_BITS  = PROD_BITS + 2;

    // request type codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_XFORM = 1'b1;

    typedef logic [NUM_CELLS-1:0][COEF_BITS-1:0] t_vec;
    typedef logic [NUM_CELLS-1:0][ACC_BITS-1:0]  t_acc;

    // one request as it travels down the cell chain
    typedef struct packed {
        logic                 req_type;
        logic [IDX_BITS-1:0]  row_sel;
        logic [IDX_BITS-1:0]  col_sel;
        logic [COEF_BITS-1:0] coef_value;
        t_vec                 vec;
        t_acc                 acc;
    } t_item;

endpackage

`default_nettype wire

FILE: hdl/m4vt_req_if.sv
// ----------------------------------------------------------------------------
// m4vt_req_if
// Request channel: coefficient load or vector transform, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface m4vt_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [1:0]         row_sel;
    logic [1:0]         col_sel;
    logic signed [31:0] coef_value;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] vec_w;

    modport source (
        output valid, req_type, row_sel, col_sel, coef_value,
               vec_x, vec_y, vec_z, vec_w,
        input  ready
    );

    modport sink (
        input  valid, req_type, row_sel, col_sel, coef_value,
               vec_x, vec_y, vec_z, vec_w,
        output ready
    );
endinterface

`default_nettype wire

FILE: hdl/m4vt_res_if.sv
// ----------------------------------------------------------------------------
// m4vt_res_if
// Result channel: transformed vector and saturation flag, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface m4vt_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic               sat_flag;

    modport source (
        output valid, out_x, out_y, out_z, out_w, sat_flag,
        input  ready
    );

    modport sink (
        input  valid, out_x, out_y, out_z, out_w, sat_flag,
        output ready
    );
endinterface

`default_nettype wire

FILE: hdl/mat4_vec4_transform_core.sv
// ----------------------------------------------------------------------------
// mat4_vec4_transform_core
// 4x4 signed fixed-point matrix times 4-element vector, with saturation.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request per valid/ready handshake. A load request
//   (req_type 0) writes one matrix coefficient at row_sel/col_sel and gives
//   no result. A transform request (req_type 1) gives one result on o_res:
//   each row's sum of (coef * vec) >> FRAC_BITS, saturated to WORD_BITS bits,
//   with sat_flag set if any element saturated.
//   Requests run down a chain of four column cells, two register stages per
//   cell, then a saturation/output register, which drives o_res. One request
//   is accepted every cycle while o_res is not stalled; loads and transforms
//   may be freely interleaved, and a load takes effect for every transform
//   accepted after it.
//   Reset clears the matrix to zero and empties the chain.
//   When o_res stalls, the chain keeps filling its empty stages and i_req
//   drops ready only once every stage holds a request.
// ----------------------------------------------------------------------------
`default_nettype none

module mat4_vec4_transform_core
    import m4vt_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    m4vt_req_if.sink  i_req,
    m4vt_res_if.source o_res
);

    localparam logic signed [ACC_BITS-1:0] SAT_HI =
        (ACC_BITS'(1) << (WORD_BITS - 1)) - ACC_BITS'(1);
    localparam logic signed [ACC_BITS-1:0] SAT_LO = ~SAT_HI;

    // cell chain links
    logic  w_valid [NUM_CELLS+1];
    logic  w_ready [NUM_CELLS+1];
    t_item w_item  [NUM_CELLS+1];

    // output register
    logic                 r_out_valid;
    logic [COEF_BITS-1:0] r_out [NUM_CELLS];
    logic                 r_sat;
    logic [COEF_BITS-1:0] n_out [NUM_CELLS];
    logic                 n_sat;
    logic                 en_out;

    // request into the head of the chain
    always_comb begin
        w_item[0]            = '0;
        w_item[0].req_type   = i_req.req_type;
        w_item[0].row_sel    = i_req.row_sel;
        w_item[0].col_sel    = i_req.col_sel;
        w_item[0].coef_value = i_req.coef_value;
        w_item[0].vec[0]     = i_req.vec_x;
        w_item[0].vec[1]     = i_req.vec_y;
        w_item[0].vec[2]     = i_req.vec_z;
        w_item[0].vec[3]     = i_req.vec_w;
    end
    assign w_valid[0]  = i_req.valid;
    assign i_req.ready = w_ready[0];

    // column cells
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        m4vt_cell #(
            .CELL_IDX  (k),
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_item  (w_item[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_item  (w_item[k+1])
        );
    end

    // loads leave the chain here without a result
    assign en_out             = !r_out_valid || o_res.ready;
    assign w_ready[NUM_CELLS] = en_out || (w_item[NUM_CELLS].req_type == REQ_LOAD);

    // saturate row sums
    always_comb begin
        logic signed [ACC_BITS-1:0] acc;
        n_sat = 1'b0;
        for (int r = 0; r < NUM_CELLS; r++) begin
            acc = $signed(w_item[NUM_CELLS].acc[r]);
            if (acc > SAT_HI) begin
                n_out[r] = SAT_HI[COEF_BITS-1:0];
                n_sat    = 1'b1;
            end else if (acc < SAT_LO) begin
                n_out[r] = SAT_LO[COEF_BITS-1:0];
                n_sat    = 1'b1;
            end else begin
                n_out[r] = acc[COEF_BITS-1:0];
            end
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= w_valid[NUM_CELLS] && (w_item[NUM_CELLS].req_type == REQ_XFORM);
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out <= n_out;
            r_sat <= n_sat;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.out_x    = r_out[0];
    assign o_res.out_y    = r_out[1];
    assign o_res.out_z    = r_out[2];
    assign o_res.out_w    = r_out[3];
    assign o_res.sat_flag = r_sat;

`ifndef SYNTH
    // an empty or draining output register lets the whole chain move
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_res.valid || o_res.ready) |-> i_req.ready)
        else $error("request not ready while output register is free");

    // a load leaving the chain never shows up as a result
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[NUM_CELLS] && (w_item[NUM_CELLS].req_type == REQ_LOAD) && en_out)
        |=> !o_res.valid)
        else $error("load request produced a result");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_res.valid)
        else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

FILE: hdl/m4vt_cell.sv
// ----------------------------------------------------------------------------
// m4vt_cell
// One column cell: holds one matrix column, multiplies it by its vector
// element and adds the shifted products into the running row sums.
// ----------------------------------------------------------------------------
`default_nettype none

module m4vt_cell
    import m4vt_pkg::*;
#(
    parameter int CELL_IDX  = 0,
    parameter int FRAC_BITS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_item      o_item
);

    localparam logic [IDX_BITS-1:0] CIDX = CELL_IDX[IDX_BITS-1:0];

    // column coefficients, one per row
    logic [COEF_BITS-1:0]        r_coef [NUM_CELLS];

    // multiply stage
    logic                        r_a_valid;
    t_item                       r_a_item;
    logic signed [PROD_BITS-1:0] r_prod [NUM_CELLS];
    logic signed [PROD_BITS-1:0] n_prod [NUM_CELLS];

    // accumulate stage
    logic                        r_b_valid;
    t_item                       r_b_item;
    t_item                       n_b_item;

    logic                        en_a;
    logic                        en_b;
    logic                        load_hit;

    // stage advance, bubbles collapse
    assign en_b    = !r_b_valid || i_ready;
    assign en_a    = !r_a_valid || en_b;
    assign o_ready = en_a;
    assign o_valid = r_b_valid;
    assign o_item  = r_b_item;

    assign load_hit = i_valid && (i_item.req_type == REQ_LOAD) && (i_item.col_sel == CIDX);

    // column times vector element
    always_comb begin
        for (int r = 0; r < NUM_CELLS; r++) begin
            n_prod[r] = $signed(r_coef[r]) * $signed(i_item.vec[CIDX]);
        end
    end

    // add floor-shifted products into the row sums
    always_comb begin
        logic signed [PROD_BITS-1:0] shifted;
        n_b_item = r_a_item;
        for (int r = 0; r < NUM_CELLS; r++) begin
            shifted = r_prod[r] >>> FRAC_BITS;
            n_b_item.acc[r] = $signed(r_a_item.acc[r]) + ACC_BITS'(shifted);
        end
    end

    // coefficient store, written as a load request passes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_CELLS; r++) begin
                r_coef[r] <= '0;
            end
        end else if (en_a && load_hit) begin
            r_coef[i_item.row_sel] <= i_item.coef_value;
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_valid <= i_valid;
            end
            if (en_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_item <= i_item;
            r_prod   <= n_prod;
        end
        if (en_b) begin
            r_b_item <= n_b_item;
        end
    end

endmodule

`default_nettype wire

FILE: verif/tb_mat4_vec4_transform_core.sv
// ----------------------------------------------------------------------------
// tb_mat4_vec4_transform_core
// Self-checking bench for the 4x4 fixed-point matrix times vector core.
// Coefficient loads and vector transforms go in on the request channel, and a
// local copy of the matrix predicts each transformed vector. Directed
// requests cover the reset matrix, identity, saturation and the rounding of
// negative products. Random request programs follow: random coefficient loads
// followed by vector streams, matrix-matrix products fed as columns, and
// single raw requests. Both sides idle at random. The bench also holds the result
// channel off long enough to stall the core's input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_mat4_vec4_transform_core
    import m4vt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_SHIFT     = 16;
    localparam int WORD_W         = 32;
    localparam int RESULT_LATENCY = 9;
    localparam int MAX_IDLE       = 8;
    localparam int SETTLE_CYCLES  = 4 * RESULT_LATENCY;
    localparam int MAX_REPORTS    = 100;
    localparam int LONG_HOLD      = 80;
    localparam longint TIMEOUT_NS = 2_000_000;

    localparam longint SAT_HI = (longint'(1) <<< (WORD_W - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    localparam logic [COEF_BITS-1:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [COEF_BITS-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic [COEF_BITS-1:0] Q_ONE    = 32'h0001_0000;
    localparam logic [COEF_BITS-1:0] Q_TINY   = 32'h0000_0001;
    localparam logic [COEF_BITS-1:0] ALL_ONES = 32'hFFFF_FFFF;

    // one request as the bench builds it, vec[0] is x
    typedef struct packed {
        logic                 req_type;
        logic [IDX_BITS-1:0]  row_sel;
        logic [IDX_BITS-1:0]  col_sel;
        logic [COEF_BITS-1:0] coef_value;
        t_vec                 vec;
    } mat_req_t;

    // one transformed vector, lanes[0] is out_x
    typedef struct packed {
        t_vec lanes;
        logic sat_flag;
    } xform_res_t;

    logic clk;
    logic rst_n;

    m4vt_req_if req_ch ();
    m4vt_res_if res_ch ();

    mat4_vec4_transform_core #(
        .FRAC_BITS(FRAC_SHIFT),
        .WORD_BITS(WORD_W)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_ch),
        .o_res  (res_ch)
    );

    // local copy of the coefficient matrix and the pending products
    logic signed [COEF_BITS-1:0] coef_mirror [NUM_CELLS][NUM_CELLS];
    xform_res_t expected_products [$];

    int    error_count     = 0;
    int    requests_sent   = 0;
    int    max_req_gap     = 0;
    int    max_res_stall   = 0;
    int    res_hold_cycles = 0;
    string lane_tag [NUM_CELLS] = '{"out_x", "out_y", "out_z", "out_w"};

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial begin : run_limit
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

    // product of the mirrored matrix and one vector, per-row saturation
    function automatic xform_res_t predict_product(input t_vec v);
        xform_res_t res;
        longint     acc;
        res.sat_flag = 1'b0;
        for (int row = 0; row < NUM_CELLS; row++) begin
            acc = 0;
            for (int col = 0; col < NUM_CELLS; col++)
                acc += (longint'(coef_mirror[row][col]) * longint'($signed(v[col])))
                       >>> FRAC_SHIFT;
            if (acc > SAT_HI) begin
                acc          = SAT_HI;
                res.sat_flag = 1'b1;
            end else if (acc < SAT_LO) begin
                acc          = SAT_LO;
                res.sat_flag = 1'b1;
            end
            res.lanes[row] = acc[COEF_BITS-1:0];
        end
        return res;
    endfunction

    // random Q16.16 value, weighted toward small and boundary magnitudes
    function automatic logic [COEF_BITS-1:0] rand_q16();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            return $urandom;
        if (pick < 65)
            return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
        if (pick < 85)
            return 32'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;
        case ($urandom_range(0, 6))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return '0;
            3: return ALL_ONES;
            4: return Q_TINY;
            5: return Q_ONE;
            default: return -Q_ONE;
        endcase
    endfunction

    // coefficient load request, vector fields carry noise
    function automatic mat_req_t make_load(input int row, input int col,
                                           input logic [COEF_BITS-1:0] value);
        mat_req_t req;
        req.req_type   = REQ_LOAD;
        req.row_sel    = row[IDX_BITS-1:0];
        req.col_sel    = col[IDX_BITS-1:0];
        req.coef_value = value;
        for (int i = 0; i < NUM_CELLS; i++)
            req.vec[i] = $urandom;
        return req;
    endfunction

    // transform request, load fields carry noise
    function automatic mat_req_t make_xform(input logic [COEF_BITS-1:0] x, y, z, w);
        mat_req_t req;
        req.req_type   = REQ_XFORM;
        req.row_sel    = IDX_BITS'($urandom);
        req.col_sel    = IDX_BITS'($urandom);
        req.coef_value = $urandom;
        req.vec[0]     = x;
        req.vec[1]     = y;
        req.vec[2]     = z;
        req.vec[3]     = w;
        return req;
    endfunction

    function automatic void note_mismatch(input string field,
                                          input logic [COEF_BITS-1:0] want, got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endfunction

    // send one request, update the mirror or queue the prediction on accept
    task automatic send_request(input mat_req_t req);
        int gap;
        gap = (max_req_gap > 0) ? $urandom_range(0, max_req_gap) : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= req.req_type;
        req_ch.row_sel    <= req.row_sel;
        req_ch.col_sel    <= req.col_sel;
        req_ch.coef_value <= req.coef_value;
        req_ch.vec_x      <= req.vec[0];
        req_ch.vec_y      <= req.vec[1];
        req_ch.vec_z      <= req.vec[2];
        req_ch.vec_w      <= req.vec[3];
        do @(posedge clk); while (!req_ch.ready);
        if (req.req_type == REQ_LOAD)
            coef_mirror[req.row_sel][req.col_sel] = req.coef_value;
        else
            expected_products.push_back(predict_product(req.vec));
        requests_sent++;
    endtask

    // stop offering requests and wait for every pending product
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_products.size() != 0);
    endtask

    // result channel ready, random stalls and an occasional long hold
    initial begin : result_sink
        int stall;
        res_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            stall = (max_res_stall > 0) ? $urandom_range(0, max_res_stall) : 0;
            if (res_hold_cycles > 0) begin
                stall           = res_hold_cycles;
                res_hold_cycles = 0;
            end
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
        end
    end

    // compare each accepted result against the oldest prediction
    always @(posedge clk) begin : result_check
        xform_res_t seen;
        xform_res_t want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            seen.lanes[0] = res_ch.out_x;
            seen.lanes[1] = res_ch.out_y;
            seen.lanes[2] = res_ch.out_z;
            seen.lanes[3] = res_ch.out_w;
            seen.sat_flag = res_ch.sat_flag;
            if (expected_products.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t ns: unexpected result, expected none, actual %h %h %h %h sat %b",
                             $time, seen.lanes[0], seen.lanes[1], seen.lanes[2],
                             seen.lanes[3], seen.sat_flag);
            end else begin
                want = expected_products.pop_front();
                for (int i = 0; i < NUM_CELLS; i++)
                    if (seen.lanes[i] !== want.lanes[i])
                        note_mismatch(lane_tag[i], want.lanes[i], seen.lanes[i]);
                if (seen.sat_flag !== want.sat_flag)
                    note_mismatch("sat_flag", 32'(want.sat_flag), 32'(seen.sat_flag));
            end
        end
    end

    // matrix is all zero after reset
    task automatic test_reset_matrix();
        max_req_gap   = 0;
        max_res_stall = 0;
        send_request(make_xform(WORD_MAX, WORD_MIN, ALL_ONES, Q_TINY));
        send_request(make_xform(rand_q16(), rand_q16(), rand_q16(), rand_q16()));
        drain_results();
    endtask

    // identity, both saturation directions, floor rounding of negative products
    task automatic test_directed_extremes();
        max_req_gap   = 0;
        max_res_stall = 0;
        // identity diagonal, transform right behind the last load
        for (int i = 0; i < NUM_CELLS; i++)
            send_request(make_load(i, i, Q_ONE));
        send_request(make_xform(WORD_MAX, WORD_MIN, ALL_ONES, Q_TINY));
        // full-scale coefficients, off-diagonal and at (3,3), push rows past both limits
        send_request(make_load(0, 1, WORD_MAX));
        send_request(make_load(1, 0, WORD_MIN));
        send_request(make_load(2, 3, ALL_ONES));
        send_request(make_load(3, 2, WORD_MIN));
        send_request(make_load(3, 3, WORD_MAX));
        send_request(make_xform(WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN));
        send_request(make_xform(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
        // tiny coefficient times a negative element floors to minus one
        send_request(make_load(2, 2, Q_TINY));
        send_request(make_xform(Q_TINY, Q_TINY, ALL_ONES, Q_TINY));
        send_request(make_xform('0, '0, '0, '0));
        drain_results();
    endtask

    // random request programs with the given idling
    task automatic test_random_programs(input int count, input int req_gap,
                                        input int res_stall);
        int target;
        int pick;
        int n_loads;
        target        = requests_sent + count;
        max_req_gap   = req_gap;
        max_res_stall = res_stall;
        while (requests_sent < target) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                // load up to sixteen coefficients at random positions, then stream vectors
                n_loads = ($urandom_range(0, 3) == 0) ? NUM_CELLS * NUM_CELLS
                                                      : $urandom_range(1, 6);
                repeat (n_loads)
                    send_request(make_load($urandom_range(0, 3), $urandom_range(0, 3),
                                           rand_q16()));
                repeat ($urandom_range(1, 8))
                    send_request(make_xform(rand_q16(), rand_q16(), rand_q16(), rand_q16()));
            end else if (pick < 8) begin
                // matrix-matrix product: full matrix, then four columns
                for (int r = 0; r < NUM_CELLS; r++)
                    for (int c = 0; c < NUM_CELLS; c++)
                        send_request(make_load(r, c, rand_q16()));
                repeat (NUM_CELLS)
                    send_request(make_xform(rand_q16(), rand_q16(), rand_q16(), rand_q16()));
            end else begin
                // raw request of either kind, every field random
                send_request('{req_type: 1'($urandom), row_sel: IDX_BITS'($urandom),
                               col_sel: IDX_BITS'($urandom), coef_value: $urandom,
                               vec: {$urandom, $urandom, $urandom, $urandom}});
            end
        end
        drain_results();
    endtask

    // long hold on results while requests keep coming back to back
    task automatic test_output_stall();
        max_req_gap     = 0;
        max_res_stall   = 0;
        res_hold_cycles = LONG_HOLD;
        for (int i = 0; i < 48; i++) begin
            if (i % 8 == 7)
                send_request(make_load($urandom_range(0, 3), $urandom_range(0, 3), rand_q16()));
            else
                send_request(make_xform(rand_q16(), rand_q16(), rand_q16(), rand_q16()));
        end
        drain_results();
    endtask

    // main sequence
    initial begin
        for (int r = 0; r < NUM_CELLS; r++)
            for (int c = 0; c < NUM_CELLS; c++)
                coef_mirror[r][c] = '0;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= REQ_LOAD;
        req_ch.row_sel    <= '0;
        req_ch.col_sel    <= '0;
        req_ch.coef_value <= '0;
        req_ch.vec_x      <= '0;
        req_ch.vec_y      <= '0;
        req_ch.vec_z      <= '0;
        req_ch.vec_w      <= '0;
        rst_n             <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_matrix();
        test_directed_extremes();
        test_random_programs(150, MAX_IDLE, MAX_IDLE);
        test_output_stall();
        test_random_programs(150, 0, 0);
        test_random_programs(150, MAX_IDLE, 0);
        test_random_programs(100, 0, MAX_IDLE);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_products.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

FILE: mat4_vec4_transform_core.f
hdl/m4vt_pkg.sv
hdl/m4vt_req_if.sv
hdl/m4vt_res_if.sv
hdl/m4vt_cell.sv
hdl/mat4_vec4_transform_core.sv
verif/tb_mat4_vec4_transform_core.sv
